### sv/wtsc_pkg.sv
// ----------------------------------------------------------------------------
// wtsc_pkg
// Shared types and constants for the watch time and setting control core:
// beat structs of both channels, mode codes, command codes and register map.
// ----------------------------------------------------------------------------
package wtsc_pkg;

    // command codes of an input beat
    localparam logic [1:0] CMD_SECOND = 2'd0;
    localparam logic [1:0] CMD_UI     = 2'd1;
    localparam logic [1:0] CMD_WAKE   = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MINUTE_CORR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOUR_CORR     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAY_CORR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MONTH_CORR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TIMEOUT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIMEOUT  = 3'd5;
    localparam int unsigned CFG_DATA_W = 16;

    // reset values of time and registers
    localparam logic [5:0]  SECONDS_RST       = 6'd30;
    localparam logic [5:0]  MINUTES_RST       = 6'd59;
    localparam logic [4:0]  HOURS_RST         = 5'd23;
    localparam logic [5:0]  MINUTE_CORR_RST   = 6'd0;
    localparam logic [5:0]  HOUR_CORR_RST     = 6'd4;
    localparam logic [4:0]  DAY_CORR_RST      = 5'd4;
    localparam logic [5:0]  MONTH_CORR_RST    = 6'd0;
    localparam logic [15:0] SHORT_TIMEOUT_RST = 16'd5000;
    localparam logic [15:0] LONG_TIMEOUT_RST  = 16'd30000;

    // last values before rollover
    localparam logic [5:0] SECOND_LAST = 6'd59;
    localparam logic [5:0] MINUTE_LAST = 6'd59;
    localparam logic [4:0] HOUR_LAST   = 5'd23;

    typedef enum logic [1:0] {
        MODE_IDLE       = 2'd0,
        MODE_DISPLAY    = 2'd1,
        MODE_SET_HOUR   = 2'd2,
        MODE_SET_MINUTE = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0] command;
        logic       left_level;
        logic       right_level;
        logic       left_press;
        logic       right_press;
    } in_beat_t;

    typedef struct packed {
        logic       display_active;
        logic [1:0] hour_tens;
        logic [3:0] hour_ones;
        logic [2:0] minute_tens;
        logic [3:0] minute_ones;
        logic       hour_mark;
        logic       minute_mark;
        logic [1:0] mode;
    } out_beat_t;

    // time of day
    typedef struct packed {
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [4:0] hours;
    } tod_t;

    // drift correction settings
    typedef struct packed {
        logic [5:0] minute;
        logic [5:0] hour;
        logic [4:0] day;
        logic [5:0] month;
    } corr_t;

endpackage

### sv/wtsc_tick.sv
// ----------------------------------------------------------------------------
// wtsc_tick
// Next time of day for a one-second tick: rollover of seconds, minutes, hours
// and the day count, drift correction and carry of excess seconds.
// ----------------------------------------------------------------------------
module wtsc_tick #(
    parameter int DAYS_PER_PERIOD = 30,
    parameter int DAY_W           = 5
) (
    input  wtsc_pkg::tod_t    tod_i,
    input  logic [DAY_W-1:0]  day_i,
    input  wtsc_pkg::corr_t   corr_i,
    output wtsc_pkg::tod_t    tod_o,
    output logic [DAY_W-1:0]  day_o,
    output logic              wake_set_o
);
    import wtsc_pkg::*;

    localparam logic [DAY_W-1:0] DAY_LAST = DAY_W'(DAYS_PER_PERIOD - 1);

    logic [7:0] sec_sum;
    logic [5:0] min_step;
    logic [1:0] carry;
    logic [7:0] sec_rem;
    logic [6:0] min_sum;

    // rollover chain with correction seconds
    always_comb begin
        tod_o      = tod_i;
        day_o      = day_i;
        wake_set_o = 1'b0;
        min_step   = tod_i.minutes;
        sec_sum    = {2'b00, tod_i.seconds} + 8'd1;
        if (tod_i.seconds == SECOND_LAST) begin
            sec_sum = {2'b00, corr_i.minute};
            if (tod_i.minutes == MINUTE_LAST) begin
                min_step   = 6'd0;
                sec_sum    = sec_sum + {2'b00, corr_i.hour};
                wake_set_o = 1'b1;
                if (tod_i.hours == HOUR_LAST) begin
                    tod_o.hours = 5'd0;
                    sec_sum     = sec_sum + {3'b000, corr_i.day};
                    if (day_i == DAY_LAST) begin
                        day_o   = '0;
                        sec_sum = sec_sum + {2'b00, corr_i.month};
                    end else begin
                        day_o = day_i + DAY_W'(1);
                    end
                end else begin
                    tod_o.hours = tod_i.hours + 5'd1;
                end
            end else begin
                min_step = tod_i.minutes + 6'd1;
            end
        end

        // excess seconds carry into minutes, at most three minutes
        if (sec_sum >= 8'd180) begin
            carry   = 2'd3;
            sec_rem = sec_sum - 8'd180;
        end else if (sec_sum >= 8'd120) begin
            carry   = 2'd2;
            sec_rem = sec_sum - 8'd120;
        end else if (sec_sum >= 8'd60) begin
            carry   = 2'd1;
            sec_rem = sec_sum - 8'd60;
        end else begin
            carry   = 2'd0;
            sec_rem = sec_sum;
        end
        min_sum = {1'b0, min_step} + {5'd0, carry};
        if (min_sum >= 7'd60) begin
            min_sum = min_sum - 7'd60;
        end
        tod_o.minutes = min_sum[5:0];
        tod_o.seconds = sec_rem[5:0];
    end

endmodule

### sv/watch_time_and_setting_control_core.sv
// ----------------------------------------------------------------------------
// watch_time_and_setting_control_core
// Watch time keeping with drift correction, mode control for display and
// setting, and BCD display digits for every beat.
// ----------------------------------------------------------------------------
//  channel  | ports                         | beat
//  ---------+-------------------------------+------------------------------
//  input    | s_valid s_ready s_data        | command, button levels, presses
//  result   | m_valid m_ready m_data        | mode, marks, BCD hour and minute
//  config   | cfg_wr_en cfg_index cfg_wdata | one register write per cycle
//
//  Time, mode and the result register update at the
//  edge that accepts the beat, and a beat is accepted every cycle while the
//  result register is empty or being drained. A stall on the result side
//  holds s_ready low until the waiting result is taken. Reset loads the
//  time 23:59:30, idle mode and the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module watch_time_and_setting_control_core #(
    parameter int DAYS_PER_PERIOD = 30,
    parameter int ON_TIME_WIDTH   = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  wtsc_pkg::in_beat_t                      s_data,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output wtsc_pkg::out_beat_t                     m_data,
    input  logic                                    cfg_wr_en,
    input  logic [wtsc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [wtsc_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
    import wtsc_pkg::*;

    localparam int DAY_W = $clog2(DAYS_PER_PERIOD + 1);
    localparam int CMP_W = (ON_TIME_WIDTH > CFG_DATA_W) ? ON_TIME_WIDTH : CFG_DATA_W;
    localparam logic [ON_TIME_WIDTH-1:0] ON_TIME_MAX = {ON_TIME_WIDTH{1'b1}};

    // configuration registers
    corr_t       corr_reg;
    logic [15:0] short_timeout_reg;
    logic [15:0] long_timeout_reg;

    // state
    tod_t                     tod_reg, tod_next;
    logic [DAY_W-1:0]         day_reg, day_next;
    mode_t                    mode_reg, mode_next;
    logic [ON_TIME_WIDTH-1:0] on_time_reg, on_time_next;
    logic                     wake_reg, wake_next;
    logic                     m_valid_reg;
    out_beat_t                m_data_reg, m_data_next;

    tod_t             tick_tod;
    logic [DAY_W-1:0] tick_day;
    logic             tick_wake;

    logic        accept;
    logic        left_ev, right_ev, force_idle;
    logic [15:0] limit;
    logic [1:0]  h_tens;
    logic [3:0]  h_ones;
    logic [2:0]  m_tens;
    logic [3:0]  m_ones;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corr_reg.minute   <= MINUTE_CORR_RST;
            corr_reg.hour     <= HOUR_CORR_RST;
            corr_reg.day      <= DAY_CORR_RST;
            corr_reg.month    <= MONTH_CORR_RST;
            short_timeout_reg <= SHORT_TIMEOUT_RST;
            long_timeout_reg  <= LONG_TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MINUTE_CORR:   corr_reg.minute   <= cfg_wdata[5:0];
                CFG_HOUR_CORR:     corr_reg.hour     <= cfg_wdata[5:0];
                CFG_DAY_CORR:      corr_reg.day      <= cfg_wdata[4:0];
                CFG_MONTH_CORR:    corr_reg.month    <= cfg_wdata[5:0];
                CFG_SHORT_TIMEOUT: short_timeout_reg <= cfg_wdata;
                CFG_LONG_TIMEOUT:  long_timeout_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // second tick rollover
    wtsc_tick #(
        .DAYS_PER_PERIOD (DAYS_PER_PERIOD),
        .DAY_W           (DAY_W)
    ) u_tick (
        .tod_i      (tod_reg),
        .day_i      (day_reg),
        .corr_i     (corr_reg),
        .tod_o      (tick_tod),
        .day_o      (tick_day),
        .wake_set_o (tick_wake)
    );

    // command handling and mode machine
    always_comb begin
        tod_next     = tod_reg;
        day_next     = day_reg;
        mode_next    = mode_reg;
        on_time_next = on_time_reg;
        wake_next    = wake_reg;
        left_ev      = s_data.left_press && s_data.left_level;
        right_ev     = s_data.right_press && s_data.right_level;
        force_idle   = 1'b0;
        limit        = (mode_reg == MODE_SET_HOUR || mode_reg == MODE_SET_MINUTE)
                       ? long_timeout_reg : short_timeout_reg;
        case (s_data.command)
            CMD_SECOND: begin
                tod_next = tick_tod;
                day_next = tick_day;
                if (tick_wake) begin
                    wake_next = 1'b1;
                end
            end
            CMD_UI: begin
                case (mode_reg)
                    MODE_IDLE: begin
                        if (wake_reg) begin
                            wake_next    = 1'b0;
                            on_time_next = '0;
                            mode_next    = MODE_DISPLAY;
                        end
                    end
                    MODE_DISPLAY: begin
                        if (s_data.left_level && s_data.right_level) begin
                            mode_next = MODE_SET_HOUR;
                        end
                        if (s_data.left_level || s_data.right_level) begin
                            on_time_next = '0;
                        end
                    end
                    MODE_SET_HOUR: begin
                        if (right_ev) begin
                            on_time_next = '0;
                            mode_next    = MODE_SET_MINUTE;
                        end
                        if (left_ev) begin
                            on_time_next   = '0;
                            tod_next.hours = (tod_reg.hours == HOUR_LAST)
                                             ? 5'd0 : tod_reg.hours + 5'd1;
                        end
                    end
                    MODE_SET_MINUTE: begin
                        if (right_ev) begin
                            on_time_next     = '0;
                            tod_next.seconds = 6'd0;
                            mode_next        = MODE_DISPLAY;
                        end
                        if (left_ev) begin
                            on_time_next     = '0;
                            tod_next.seconds = 6'd0;
                            tod_next.minutes = (tod_reg.minutes == MINUTE_LAST)
                                               ? 6'd0 : tod_reg.minutes + 6'd1;
                        end
                        force_idle = s_data.left_level && s_data.right_level;
                    end
                    default: ;
                endcase
                // on-time limit against the mode held at the start of the tick
                if (mode_next != MODE_IDLE) begin
                    if (force_idle || (CMP_W'(on_time_next) > CMP_W'(limit))) begin
                        mode_next = MODE_IDLE;
                        wake_next = 1'b0;
                    end else if (on_time_next != ON_TIME_MAX) begin
                        on_time_next = on_time_next + ON_TIME_WIDTH'(1);
                    end
                end
            end
            CMD_WAKE: wake_next = 1'b1;
            default: ;
        endcase
    end

    // bcd digits of the new time, midnight shown as 24:00
    always_comb begin
        if (tod_next.hours >= 5'd20) begin
            h_tens = 2'd2;
            h_ones = 4'(tod_next.hours - 5'd20);
        end else if (tod_next.hours >= 5'd10) begin
            h_tens = 2'd1;
            h_ones = 4'(tod_next.hours - 5'd10);
        end else begin
            h_tens = 2'd0;
            h_ones = tod_next.hours[3:0];
        end
        if (tod_next.minutes >= 6'd50) begin
            m_tens = 3'd5;
            m_ones = 4'(tod_next.minutes - 6'd50);
        end else if (tod_next.minutes >= 6'd40) begin
            m_tens = 3'd4;
            m_ones = 4'(tod_next.minutes - 6'd40);
        end else if (tod_next.minutes >= 6'd30) begin
            m_tens = 3'd3;
            m_ones = 4'(tod_next.minutes - 6'd30);
        end else if (tod_next.minutes >= 6'd20) begin
            m_tens = 3'd2;
            m_ones = 4'(tod_next.minutes - 6'd20);
        end else if (tod_next.minutes >= 6'd10) begin
            m_tens = 3'd1;
            m_ones = 4'(tod_next.minutes - 6'd10);
        end else begin
            m_tens = 3'd0;
            m_ones = tod_next.minutes[3:0];
        end
        if (tod_next.hours == 5'd0 && tod_next.minutes == 6'd0) begin
            h_tens = 2'd2;
            h_ones = 4'd4;
        end
        m_data_next.display_active = (mode_next != MODE_IDLE);
        m_data_next.hour_tens      = h_tens;
        m_data_next.hour_ones      = h_ones;
        m_data_next.minute_tens    = m_tens;
        m_data_next.minute_ones    = m_ones;
        m_data_next.hour_mark      = (mode_next == MODE_SET_HOUR);
        m_data_next.minute_mark    = (mode_next == MODE_SET_MINUTE);
        m_data_next.mode           = mode_next;
    end

    // state registers, updated per accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tod_reg.seconds <= SECONDS_RST;
            tod_reg.minutes <= MINUTES_RST;
            tod_reg.hours   <= HOURS_RST;
            day_reg         <= '0;
            mode_reg        <= MODE_IDLE;
            on_time_reg     <= '0;
            wake_reg        <= 1'b0;
        end else if (accept) begin
            tod_reg     <= tod_next;
            day_reg     <= day_next;
            mode_reg    <= mode_next;
            on_time_reg <= on_time_next;
            wake_reg    <= wake_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    // time fields stay in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        tod_reg.seconds <= SECOND_LAST && tod_reg.minutes <= MINUTE_LAST
        && tod_reg.hours <= HOUR_LAST)
        else $error("time of day out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        day_reg < DAY_W'(DAYS_PER_PERIOD))
        else $error("day count out of range");

    // an accepted beat always leaves a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted beat produced no result");

    // result marks agree with the reported mode
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.display_active == (m_data.mode != MODE_IDLE))
        && (m_data.hour_mark == (m_data.mode == MODE_SET_HOUR))
        && (m_data.minute_mark == (m_data.mode == MODE_SET_MINUTE)))
        else $error("result marks disagree with mode");

    // the result mode is the mode held after the beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_data.mode == mode_reg)
        else $error("result mode differs from state");

endmodule
